### design/mersenne_twister_generator_macros.svh
// assertion macros shared by the generator rtl
`ifndef MERSENNE_TWISTER_GENERATOR_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define MTG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mtg assertion failed");

// next-cycle implication, checked on every rising clock edge out of reset
`define MTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mtg assertion failed");

`endif

### design/mtg_pkg.sv
`default_nettype none
package mtg_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

  // input function codes
  localparam logic FUNC_GENERATE = 1'b0;
  localparam logic FUNC_SEED     = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEED
  } seed_state_e;

  // control handed from the seed sequencer to the cell chain
  typedef struct packed {
    logic              busy;
    logic              shift;
    logic [WORD_W-1:0] word;
  } seed_ctrl_t;

  // twist of the oldest word with its neighbor and the far tap
  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] w_cur,
                                              input logic [WORD_W-1:0] w_nxt,
                                              input logic [WORD_W-1:0] w_far);
    logic [WORD_W-1:0] y;
    y = {w_cur[WORD_W-1], w_nxt[WORD_W-2:0]};
    return w_far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
  endfunction

  // output tempering
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

### design/mersenne_twister_generator.sv
// mt19937 generator built as a circular chain of 32-bit word cells
// generate: random_word_o with valid_o in the cycle after start is taken, one word per cycle while not busy
// seed: busy after the accepting edge while the sequencer fills the state (one recurrence
//   multiply per cycle through the tail cell), no result word
// reset clears the sequencer and the output strobe; the cells hold no value
//   until the first seed, and the receiver cannot stall
`default_nettype none
`include "mersenne_twister_generator_macros.svh"
module mersenne_twister_generator #(
  parameter int unsigned STATE_WORDS  = mtg_pkg::STATE_WORDS,
  parameter int unsigned TWIST_OFFSET = mtg_pkg::TWIST_OFFSET
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       func_i,
  input  wire logic [mtg_pkg::WORD_W-1:0] seed_i,
  output logic                            valid_o,
  output logic      [mtg_pkg::WORD_W-1:0] random_word_o
);
  import mtg_pkg::*;

  seed_ctrl_t        seed_ctrl;
  logic              accept;
  logic              gen_accept;
  logic              seed_accept;
  logic              chain_shift;
  logic [WORD_W-1:0] tail_in;
  logic [WORD_W-1:0] fresh;
  logic [WORD_W-1:0] chain_w [STATE_WORDS];
  logic              valid_q, valid_d;
  logic [WORD_W-1:0] word_q, word_d;

  // handshake decode
  assign busy        = seed_ctrl.busy;
  assign accept      = start & ~seed_ctrl.busy;
  assign gen_accept  = accept & (func_i == FUNC_GENERATE);
  assign seed_accept = accept & (func_i == FUNC_SEED);

  // twist on fixed taps: head is the current position
  assign fresh = twist(chain_w[0], chain_w[1], chain_w[TWIST_OFFSET]);

  // word entering the tail cell
  always_comb begin
    if (seed_ctrl.shift) begin
      tail_in = seed_ctrl.word;
    end else if (seed_accept) begin
      tail_in = seed_i;
    end else begin
      tail_in = fresh;
    end
  end

  assign chain_shift = accept | seed_ctrl.shift;

  // row of word cells, each takes its upper neighbor on a shift
  for (genvar k = 0; k < STATE_WORDS; k++) begin : g_cell
    if (k == STATE_WORDS - 1) begin : g_tail
      mtg_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(chain_shift),
        .data_i (tail_in),
        .data_o (chain_w[k])
      );
    end else begin : g_body
      mtg_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(chain_shift),
        .data_i (chain_w[k+1]),
        .data_o (chain_w[k])
      );
    end
  end

  // seed sequencer
  mtg_seed_unit #(
    .STATE_WORDS(STATE_WORDS)
  ) u_seed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_start_i(seed_accept),
    .tail_word_i (chain_w[STATE_WORDS-1]),
    .ctrl_o      (seed_ctrl)
  );

  // output word register
  assign valid_d = gen_accept;
  assign word_d  = gen_accept ? temper(fresh) : word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o       = valid_q;
  assign random_word_o = word_q;

  `MTG_ASSERT_NEXT(a_gen_gives_word, gen_accept, valid_o)
  `MTG_ASSERT_NEXT(a_no_stray_word, !gen_accept, !valid_o)
  `MTG_ASSERT_NOW(a_no_word_while_seeding, busy, !valid_o)

endmodule
`default_nettype wire

### design/mtg_cell.sv
`default_nettype none
module mtg_cell (
  input  wire logic                      clk_i,
  input  wire logic                      shift_i,
  input  wire logic [mtg_pkg::WORD_W-1:0] data_i,
  output logic      [mtg_pkg::WORD_W-1:0] data_o
);
  import mtg_pkg::*;

  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] word_d;

  // take the neighbor's word on a shift, hold otherwise
  assign word_d = shift_i ? data_i : word_q;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign data_o = word_q;

endmodule
`default_nettype wire

### design/mtg_seed_unit.sv
`default_nettype none
`include "mersenne_twister_generator_macros.svh"
module mtg_seed_unit #(
  parameter int unsigned STATE_WORDS = mtg_pkg::STATE_WORDS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       seed_start_i,
  input  wire logic [mtg_pkg::WORD_W-1:0] tail_word_i,
  output mtg_pkg::seed_ctrl_t             ctrl_o
);
  import mtg_pkg::*;

  localparam int unsigned IDX_W = $clog2(STATE_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

  seed_state_e       state_q, state_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] prod;

  // multiplier recurrence on the word last shifted into the tail cell
  assign mixed = tail_word_i ^ (tail_word_i >> 30);
  assign prod  = WORD_W'(SEED_MULT * mixed);

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and chain control
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ctrl_o.busy  = 1'b0;
    ctrl_o.shift = 1'b0;
    ctrl_o.word  = prod + {{(WORD_W-IDX_W){1'b0}}, cnt_q};
    case (state_q)
      ST_IDLE: begin
        if (seed_start_i) begin
          state_d = ST_SEED;
          cnt_d   = IDX_W'(1);
        end
      end
      ST_SEED: begin
        ctrl_o.busy  = 1'b1;
        ctrl_o.shift = 1'b1;
        cnt_d        = cnt_q + IDX_W'(1);
        if (cnt_q == LAST_IDX) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  `MTG_ASSERT_NEXT(a_seed_starts, (state_q == ST_IDLE) && seed_start_i, state_q == ST_SEED)
  `MTG_ASSERT_NEXT(a_seed_runs_on, (state_q == ST_SEED) && (cnt_q != LAST_IDX),
                   state_q == ST_SEED)
  `MTG_ASSERT_NOW(a_cnt_nonzero, state_q == ST_SEED, cnt_q != '0)

endmodule
`default_nettype wire

### verif/tb_mersenne_twister_generator.sv
`default_nettype none
module tb_mersenne_twister_generator;
  import mtg_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned RANDOM_CMDS = 1500;

  // one command word as the sender presents it
  typedef struct {
    logic              func;
    logic [WORD_W-1:0] seed;
    bit                drain_first;
  } gen_cmd_t;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start  = 1'b0;
  logic              func_i = FUNC_GENERATE;
  logic [WORD_W-1:0] seed_i = '0;
  logic              busy;
  logic              valid_o;
  logic [WORD_W-1:0] random_word_o;

  mersenne_twister_generator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .seed_i        (seed_i),
    .valid_o       (valid_o),
    .random_word_o (random_word_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  gen_cmd_t          pending_cmds[$];
  logic [WORD_W-1:0] expected_words[$];

  // predicted generator state
  logic [WORD_W-1:0] mt_words[STATE_WORDS];
  int unsigned       mt_pos = 0;

  bit          took_word = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  // multiplier recurrence fill of the whole store
  function automatic void reseed_state(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] prev;
    mt_words[0] = s;
    for (int unsigned i = 1; i < STATE_WORDS; i++) begin
      prev = mt_words[i-1];
      mt_words[i] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
    end
    mt_pos = 0;
  endfunction

  // twist the word at the position in place and return it tempered
  function automatic logic [WORD_W-1:0] twist_and_temper();
    int unsigned       nxt;
    int unsigned       far_idx;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] fresh;
    logic [WORD_W-1:0] t;
    nxt     = (mt_pos + 1) % STATE_WORDS;
    far_idx = (mt_pos + TWIST_OFFSET) % STATE_WORDS;
    mix     = {mt_words[mt_pos][WORD_W-1], mt_words[nxt][WORD_W-2:0]};
    fresh   = mt_words[far_idx] ^ {1'b0, mix[WORD_W-1:1]} ^ (mix[0] ? TWIST_MATRIX : '0);
    mt_words[mt_pos] = fresh;
    mt_pos = nxt;
    t = fresh ^ (fresh >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  // sender gap: mostly none or short, a few long, with runs of back-to-back words
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) begin
      burst_left = $urandom_range(100, 300);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_cmd(input logic func, input logic [WORD_W-1:0] seed,
                          input bit drain_first);
    gen_cmd_t c;
    c.func        = func;
    c.seed        = seed;
    c.drain_first = drain_first;
    pending_cmds.push_back(c);
  endtask

  // driver: present the oldest pending word, hold it until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took_word) begin
        pending_cmds.delete(0);
        gap_left = pick_gap();
      end
      if (!(start && !took_word)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain_first && expected_words.size() != 0)) begin
          start  <= 1'b1;
          func_i <= pending_cmds[0].func;
          seed_i <= pending_cmds[0].seed;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: check results, predict taken words, watch for a hang
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      took_word = 1'b0;
    end else begin
      if (valid_o) begin
        if (expected_words.size() == 0) begin
          $display("%0t random_word: expected none, actual %h", $time, random_word_o);
          mismatch_count++;
        end else begin
          if (random_word_o !== expected_words[0]) begin
            $display("%0t random_word: expected %h, actual %h",
                     $time, expected_words[0], random_word_o);
            mismatch_count++;
          end
          expected_words.delete(0);
        end
      end
      took_word = start && !busy;
      if (took_word) begin
        if (func_i == FUNC_SEED) reseed_state(seed_i);
        else expected_words.push_back(twist_and_temper());
      end
      if (took_word || valid_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t timeout with %0d words pending and %0d results due",
                 $time, pending_cmds.size(), expected_words.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned since_seed;
    logic [WORD_W-1:0] s;

    // directed: seed extremes, back-to-back seeds, a drain pause
    push_cmd(FUNC_SEED, 32'h0000_0000, 1'b0);
    push_cmd(FUNC_GENERATE, 32'hffff_ffff, 1'b0);
    push_cmd(FUNC_GENERATE, 32'h0000_0000, 1'b0);
    push_cmd(FUNC_GENERATE, $urandom, 1'b0);
    push_cmd(FUNC_SEED, 32'hffff_ffff, 1'b0);
    push_cmd(FUNC_GENERATE, $urandom, 1'b0);
    push_cmd(FUNC_GENERATE, $urandom, 1'b1);
    push_cmd(FUNC_SEED, 32'h0000_1571, 1'b0);
    push_cmd(FUNC_SEED, 32'h0000_1571, 1'b0);
    push_cmd(FUNC_GENERATE, $urandom, 1'b0);
    push_cmd(FUNC_GENERATE, $urandom, 1'b0);
    push_cmd(FUNC_GENERATE, $urandom, 1'b0);
    push_cmd(FUNC_SEED, 32'haaaa_aaaa, 1'b1);
    push_cmd(FUNC_GENERATE, $urandom, 1'b0);
    push_cmd(FUNC_SEED, 32'h5555_5555, 1'b0);
    push_cmd(FUNC_GENERATE, $urandom, 1'b0);
    push_cmd(FUNC_GENERATE, $urandom, 1'b0);
    push_cmd(FUNC_SEED, $urandom, 1'b0);

    // random: long generate runs so the position wraps, rare reseeds
    since_seed = 0;
    for (int unsigned i = 0; i < RANDOM_CMDS; i++) begin
      if (since_seed >= 700 && $urandom_range(0, 299) == 0) begin
        case ($urandom_range(0, 3))
          0:       s = '0;
          1:       s = '1;
          default: s = $urandom;
        endcase
        push_cmd(FUNC_SEED, s, $urandom_range(0, 1));
        since_seed = 0;
      end else begin
        push_cmd(FUNC_GENERATE, $urandom, $urandom_range(0, 59) == 0);
        since_seed++;
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
